@@ src/rmq_pkg.sv @@
// Shared types, constants and width helpers for the rotation-matrix-to-quaternion block.
package rmq_pkg;

    // Field widths of the payloads
    localparam int ENTRY_W = 16;
    localparam int QW_W    = 15;
    localparam int QV_W    = 16;

    // Default number of fraction bits of the fixed-point format
    localparam int FRAC_BITS_DEF = 14;

    // Root bits resolved by one square-root pipeline stage
    localparam int SQRT_STEPS = 2;

    // Quaternion lanes
    localparam int LANES  = 4;
    localparam int LANE_W = 0;
    localparam int LANE_X = 1;
    localparam int LANE_Y = 2;
    localparam int LANE_Z = 3;

    // Matrix as it arrives
    typedef struct packed {
        logic signed [ENTRY_W-1:0] r00;
        logic signed [ENTRY_W-1:0] r01;
        logic signed [ENTRY_W-1:0] r02;
        logic signed [ENTRY_W-1:0] r10;
        logic signed [ENTRY_W-1:0] r11;
        logic signed [ENTRY_W-1:0] r12;
        logic signed [ENTRY_W-1:0] r20;
        logic signed [ENTRY_W-1:0] r21;
        logic signed [ENTRY_W-1:0] r22;
    } rmq_in_t;

    // Quaternion result
    typedef struct packed {
        logic        [QW_W-1:0] quat_w;
        logic signed [QV_W-1:0] quat_x;
        logic signed [QV_W-1:0] quat_y;
        logic signed [QV_W-1:0] quat_z;
    } rmq_out_t;

    // Width of the clamped (non-negative) diagonal sum
    function automatic int sum_uw(input int frac);
        int base;
        base = (frac > ENTRY_W + 1) ? frac : ENTRY_W + 1;
        return base + 1;
    endfunction

    // Width of the integer square root of (sum << frac)
    function automatic int root_w(input int frac);
        return (sum_uw(frac) + frac + 1) / 2;
    endfunction

endpackage

@@ src/rmq_front.sv @@
// Input stage: diagonal sums, clamping, radicand forming and off-diagonal signs.
module rmq_front
    import rmq_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                                        aclk,
    input  logic                                        aresetn,
    input  logic                                        in_valid,
    output logic                                        in_ready,
    input  rmq_in_t                                     in_data,
    output logic                                        out_valid,
    input  logic                                        out_ready,
    output logic [LANES-1:0][2*root_w(FRAC_BITS)-1:0]   out_rad,
    output logic [LANES-2:0]                            out_neg
);

    localparam int SU_W  = sum_uw(FRAC_BITS);
    localparam int SUM_W = SU_W + 1;
    localparam int RW    = root_w(FRAC_BITS);
    localparam int RAD_W = 2 * RW;
    localparam int DIF_W = ENTRY_W + 1;

    logic                              valid_reg;
    logic [LANES-1:0][RAD_W-1:0]       rad_reg;
    logic [LANES-2:0]                  neg_reg;
    logic [LANES-1:0][RAD_W-1:0]       rad_next;
    logic [LANES-2:0]                  neg_next;

    logic signed [SUM_W-1:0] one_s;
    logic signed [SUM_W-1:0] e00, e11, e22;
    logic signed [SUM_W-1:0] sum [LANES];
    logic signed [DIF_W-1:0] dif [LANES-1];

    assign in_ready = !valid_reg || out_ready;

    // Sign-extend the diagonal and form 1 +/- the three entries per lane
    always_comb begin
        one_s = SUM_W'(1) << FRAC_BITS;
        e00   = {{(SUM_W-ENTRY_W){in_data.r00[ENTRY_W-1]}}, in_data.r00};
        e11   = {{(SUM_W-ENTRY_W){in_data.r11[ENTRY_W-1]}}, in_data.r11};
        e22   = {{(SUM_W-ENTRY_W){in_data.r22[ENTRY_W-1]}}, in_data.r22};
        sum[LANE_W] = one_s + e00 + e11 + e22;
        sum[LANE_X] = one_s + e00 - e11 - e22;
        sum[LANE_Y] = one_s - e00 + e11 - e22;
        sum[LANE_Z] = one_s - e00 - e11 + e22;
        for (int i = 0; i < LANES; i++) begin
            // negative sum clamps to zero; radicand is sum << FRAC_BITS
            if (sum[i][SUM_W-1]) begin
                rad_next[i] = '0;
            end else begin
                rad_next[i] = RAD_W'({sum[i][SU_W-1:0], {FRAC_BITS{1'b0}}});
            end
        end
    end

    // Off-diagonal differences; only their signs are kept
    always_comb begin
        dif[0] = {in_data.r21[ENTRY_W-1], in_data.r21} - {in_data.r12[ENTRY_W-1], in_data.r12};
        dif[1] = {in_data.r02[ENTRY_W-1], in_data.r02} - {in_data.r20[ENTRY_W-1], in_data.r20};
        dif[2] = {in_data.r10[ENTRY_W-1], in_data.r10} - {in_data.r01[ENTRY_W-1], in_data.r01};
        for (int i = 0; i < LANES - 1; i++) begin
            neg_next[i] = dif[i][DIF_W-1];
        end
    end

    // Stage register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            rad_reg <= rad_next;
            neg_reg <= neg_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_rad   = rad_reg;
    assign out_neg   = neg_reg;

endmodule

@@ src/rmq_sqrt_stage.sv @@
// One square-root pipeline stage: resolves N_STEPS root bits for all four lanes.
module rmq_sqrt_stage
    import rmq_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int N_STEPS   = SQRT_STEPS
) (
    input  logic                                        aclk,
    input  logic                                        aresetn,
    input  logic                                        in_valid,
    output logic                                        in_ready,
    input  logic [LANES-1:0][2*root_w(FRAC_BITS)-1:0]   in_rad,
    input  logic [LANES-1:0][root_w(FRAC_BITS)-1:0]     in_root,
    input  logic [LANES-1:0][root_w(FRAC_BITS)+1:0]     in_rem,
    input  logic [LANES-2:0]                            in_neg,
    output logic                                        out_valid,
    input  logic                                        out_ready,
    output logic [LANES-1:0][2*root_w(FRAC_BITS)-1:0]   out_rad,
    output logic [LANES-1:0][root_w(FRAC_BITS)-1:0]     out_root,
    output logic [LANES-1:0][root_w(FRAC_BITS)+1:0]     out_rem,
    output logic [LANES-2:0]                            out_neg
);

    localparam int RW    = root_w(FRAC_BITS);
    localparam int RAD_W = 2 * RW;
    localparam int REM_W = RW + 2;
    localparam int CUR_W = RW + 3;

    logic                          valid_reg;
    logic [LANES-1:0][RAD_W-1:0]   rad_reg,  rad_next;
    logic [LANES-1:0][RW-1:0]      root_reg, root_next;
    logic [LANES-1:0][REM_W-1:0]   rem_reg,  rem_next;
    logic [LANES-2:0]              neg_reg;

    assign in_ready = !valid_reg || out_ready;

    // Digit-by-digit root: bring down two radicand bits, try (root << 2) | 1
    always_comb begin
        logic [RAD_W-1:0] d;
        logic [RW-1:0]    r;
        logic [CUR_W-1:0] m;
        logic [CUR_W-1:0] cur;
        logic [CUR_W-1:0] trial;
        for (int i = 0; i < LANES; i++) begin
            d = in_rad[i];
            r = in_root[i];
            m = CUR_W'(in_rem[i]);
            for (int s = 0; s < N_STEPS; s++) begin
                cur   = {m[CUR_W-3:0], d[RAD_W-1 -: 2]};
                trial = CUR_W'({r, 2'b01});
                if (cur >= trial) begin
                    m = cur - trial;
                    r = {r[RW-2:0], 1'b1};
                end else begin
                    m = cur;
                    r = {r[RW-2:0], 1'b0};
                end
                d = d << 2;
            end
            rad_next[i]  = d;
            root_next[i] = r;
            rem_next[i]  = m[REM_W-1:0];
        end
    end

    // Stage register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            rad_reg  <= rad_next;
            root_reg <= root_next;
            rem_reg  <= rem_next;
            neg_reg  <= in_neg;
        end
    end

    assign out_valid = valid_reg;
    assign out_rad   = rad_reg;
    assign out_root  = root_reg;
    assign out_rem   = rem_reg;
    assign out_neg   = neg_reg;

endmodule

@@ src/rmq_back.sv @@
// Output stage: halve the root, saturate, apply signs and hold the result.
module rmq_back
    import rmq_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    input  logic                                      in_valid,
    output logic                                      in_ready,
    input  logic [LANES-1:0][root_w(FRAC_BITS)-1:0]   in_root,
    input  logic [LANES-2:0]                          in_neg,
    output logic                                      out_valid,
    input  logic                                      out_ready,
    output rmq_out_t                                  out_data
);

    localparam int RW  = root_w(FRAC_BITS);
    localparam int M_W = (RW > QV_W + 1) ? RW : QV_W + 1;

    logic                     valid_reg;
    rmq_out_t                 data_reg, data_next;
    logic [M_W-1:0]           one_m;
    logic [M_W-1:0]           mag [LANES];
    logic [M_W-1:0]           sgn [LANES-1];

    assign in_ready = !valid_reg || out_ready;

    // Magnitude = root / 2, saturated to one; x, y, z take the difference sign
    always_comb begin
        one_m = M_W'(1) << FRAC_BITS;
        for (int i = 0; i < LANES; i++) begin
            mag[i] = M_W'(in_root[i] >> 1);
            if (mag[i] > one_m) begin
                mag[i] = one_m;
            end
        end
        for (int i = 0; i < LANES - 1; i++) begin
            sgn[i] = in_neg[i] ? (~mag[i+1] + M_W'(1)) : mag[i+1];
        end
        data_next.quat_w = mag[LANE_W][QW_W-1:0];
        data_next.quat_x = sgn[LANE_X-1][QV_W-1:0];
        data_next.quat_y = sgn[LANE_Y-1][QV_W-1:0];
        data_next.quat_z = sgn[LANE_Z-1][QV_W-1:0];
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

@@ src/rotation_matrix_to_quaternion.sv @@
// Top level of the pipelined rotation-matrix-to-quaternion converter.
//
// Converts a 3x3 rotation matrix in signed fixed point (FRAC_BITS fraction
// bits, 1.0 = 1 << FRAC_BITS) into the unit quaternion w, x, y, z in the same
// format. One matrix is taken per clock cycle when the output side keeps up.
// R = root_w(FRAC_BITS) is the width of the integer square root (R = 16 at
// FRAC_BITS = 14); the depth is set by the square-root pipeline, which
// resolves two root bits of all four components per stage. Each stage holds
// its item when the next one is full, so bubbles close up and a finished
// result waiting at the output keeps new matrices from entering only once
// every stage holds an item.
module rotation_matrix_to_quaternion
    import rmq_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  rmq_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output rmq_out_t m_data
);

    localparam int RW    = root_w(FRAC_BITS);
    localparam int RAD_W = 2 * RW;
    localparam int REM_W = RW + 2;
    localparam int NS    = (RW + SQRT_STEPS - 1) / SQRT_STEPS;

    // Inter-stage links; index 0 is the front stage output
    logic                          vld_s  [NS+1];
    logic                          rdy_s  [NS+1];
    logic [LANES-1:0][RAD_W-1:0]   rad_s  [NS+1];
    logic [LANES-1:0][RW-1:0]      root_s [NS+1];
    logic [LANES-1:0][REM_W-1:0]   rem_s  [NS+1];
    logic [LANES-2:0]              neg_s  [NS+1];

    // Sums and signs
    rmq_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_data   (s_data),
        .out_valid (vld_s[0]),
        .out_ready (rdy_s[0]),
        .out_rad   (rad_s[0]),
        .out_neg   (neg_s[0])
    );

    assign root_s[0] = '0;
    assign rem_s[0]  = '0;

    // Square-root pipeline
    for (genvar k = 0; k < NS; k++) begin : g_sqrt
        localparam int STEPS = (RW - k * SQRT_STEPS < SQRT_STEPS) ?
                               (RW - k * SQRT_STEPS) : SQRT_STEPS;
        rmq_sqrt_stage #(
            .FRAC_BITS (FRAC_BITS),
            .N_STEPS   (STEPS)
        ) u_stage (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (vld_s[k]),
            .in_ready  (rdy_s[k]),
            .in_rad    (rad_s[k]),
            .in_root   (root_s[k]),
            .in_rem    (rem_s[k]),
            .in_neg    (neg_s[k]),
            .out_valid (vld_s[k+1]),
            .out_ready (rdy_s[k+1]),
            .out_rad   (rad_s[k+1]),
            .out_root  (root_s[k+1]),
            .out_rem   (rem_s[k+1]),
            .out_neg   (neg_s[k+1])
        );
    end

    // Scaling, saturation, signs and output register
    rmq_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (vld_s[NS]),
        .in_ready  (rdy_s[NS]),
        .in_root   (root_s[NS]),
        .in_neg    (neg_s[NS]),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (m_data)
    );

endmodule
